/* rtl/usws_pkg.sv */
// Package with sizes, operation and status codes of the unique value set unit.
package usws_pkg;

	// Store depth, the index width that follows from it, and the other widths.
	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = 7;
	localparam int VAL_W    = 32;
	localparam int SUM_W    = 38;
	localparam int FRAC_W   = 8;
	localparam int DIV_W    = SUM_W + FRAC_W;
	localparam int DCNT_W   = $clog2(DIV_W + 1);
	localparam int MEAN_W   = 40;

	// Operation codes.
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;
	localparam logic [1:0] MODE_COUNT  = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EMPTY     = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_NOT_FOUND = 3'd3;
	localparam logic [2:0] ST_FULL      = 3'd4;

endpackage

/* rtl/usws_ram.sv */
// Generic single write port, single read port RAM with registered read data.
module usws_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* rtl/unique_set_with_statistics_unit.sv */
// Top level of the unique value set unit with min, max and mean statistics.
//
// Input channel: in_valid/in_ready with mode and value. Output channel:
// out_valid/out_ready with status, occurrences, entries, smallest, largest
// and mean_fixed. Every accepted item gives exactly one result item.
// One item is worked on at a time; in_ready is high only while the
// sequencer is idle. The stored values live in a RAM with one read and
// one write port and are visited one entry per cycle, in these steps:
//   scan for match, min and max,
//   closing the gap after a removal,
//   mean: a load step and a bit-serial divider,
//   result: loaded into the output register.
// Clear items and non-add items on an empty set skip the scan and divider.
// A result waits in the output register while out_ready is low; the next
// item is accepted meanwhile, and its result is held back until the
// output register is free. Reset empties the set and drops any result.
module unique_set_with_statistics_unit
	import usws_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               mode,
	input  logic signed [VAL_W-1:0]  value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [2:0]               status,
	output logic                     occurrences,
	output logic [CNT_W-1:0]         entries,
	output logic signed [VAL_W-1:0]  smallest,
	output logic signed [VAL_W-1:0]  largest,
	output logic signed [MEAN_W-1:0] mean_fixed
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_DIVLD = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

	logic [2:0]               state_q;
	logic [1:0]               mode_q;
	logic signed [VAL_W-1:0]  val_q;
	logic [CNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         idx_q;
	logic                     pend_q;
	logic [CNT_W-1:0]         pend_idx_q;
	logic                     match_q;
	logic [CNT_W-1:0]         slot_q;
	logic                     have_q;
	logic signed [VAL_W-1:0]  lo_q;
	logic signed [VAL_W-1:0]  hi_q;
	logic [2:0]               status_q;
	logic                     occ_q;
	logic [DIV_W-1:0]         dvd_q;
	logic [DIV_W-1:0]         quo_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     neg_q;
	logic [DCNT_W-1:0]        div_cnt_q;

	logic                     out_valid_q;
	logic [2:0]               out_status_q;
	logic                     out_occ_q;
	logic [CNT_W-1:0]         out_entries_q;
	logic signed [VAL_W-1:0]  out_lo_q;
	logic signed [VAL_W-1:0]  out_hi_q;
	logic signed [MEAN_W-1:0] out_mean_q;

	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [VAL_W-1:0]         ram_wdata;
	logic signed [VAL_W-1:0]  rd_data;

	logic                     scan_done;
	logic                     shift_done;
	logic                     incl_val;
	logic [CNT_W-1:0]         pend_idx_m1;
	logic signed [SUM_W-1:0]  val_ext;
	logic signed [DIV_W-1:0]  prod;
	logic [DIV_W-1:0]         prod_mag;
	logic [CNT_W:0]           trial;
	logic                     trial_ge;
	logic [DIV_W-1:0]         mean_full;

	usws_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q[IDX_W-1:0]),
		.rdata(rd_data)
	);

	assign scan_done   = (idx_q == count_q) && !pend_q;
	assign shift_done  = (idx_q >= count_q) && !pend_q;
	assign pend_idx_m1 = pend_idx_q - 1'b1;
	assign val_ext     = SUM_W'(val_q);
	assign prod        = {sum_q, {FRAC_W{1'b0}}};
	assign prod_mag    = sum_q[SUM_W-1] ? (~prod + 1'b1) : prod;
	assign trial       = {rem_q, dvd_q[DIV_W-1]};
	assign trial_ge    = trial >= {1'b0, count_q};
	assign mean_full   = neg_q ? (~quo_q + 1'b1) : quo_q;

	// The new value counts toward min and max when it ends up in the set.
	always_comb begin
		if (mode_q == MODE_ADD) begin
			incl_val = match_q || (count_q < CAP);
		end else begin
			incl_val = (mode_q == MODE_COUNT) && match_q;
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[IDX_W-1:0];
		ram_wdata = val_q;
		case (state_q)
			S_SCAN: begin
				ram_we = scan_done && (mode_q == MODE_ADD) && !match_q && (count_q < CAP);
			end
			S_SHIFT: begin
				ram_we    = pend_q;
				ram_waddr = pend_idx_m1[IDX_W-1:0];
				ram_wdata = rd_data;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						mode_q   <= mode;
						val_q    <= value;
						occ_q    <= 1'b0;
						idx_q    <= '0;
						pend_q   <= 1'b0;
						match_q  <= 1'b0;
						have_q   <= 1'b0;
						if ((mode != MODE_ADD) && (count_q == '0)) begin
							status_q <= ST_EMPTY;
							state_q  <= S_DONE;
						end else if (mode == MODE_CLEAR) begin
							status_q <= ST_OK;
							count_q  <= '0;
							sum_q    <= '0;
							state_q  <= S_DONE;
						end else begin
							status_q <= ST_OK;
							state_q  <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// Values are distinct, so min and max are kept over the
					// entries that differ from the operand.
					if (pend_q) begin
						if (rd_data == val_q) begin
							match_q <= 1'b1;
							slot_q  <= pend_idx_q;
						end else begin
							have_q <= 1'b1;
							if (!have_q || (rd_data < lo_q)) begin
								lo_q <= rd_data;
							end
							if (!have_q || (rd_data > hi_q)) begin
								hi_q <= rd_data;
							end
						end
					end
					if (idx_q < count_q) begin
						idx_q      <= idx_q + 1'b1;
						pend_q     <= 1'b1;
						pend_idx_q <= idx_q;
					end else begin
						pend_q <= 1'b0;
					end
					if (scan_done) begin
						if (incl_val) begin
							if (!have_q || (val_q < lo_q)) begin
								lo_q <= val_q;
							end
							if (!have_q || (val_q > hi_q)) begin
								hi_q <= val_q;
							end
						end
						case (mode_q)
							MODE_ADD: begin
								state_q <= S_DIVLD;
								if (match_q) begin
									status_q <= ST_DUPLICATE;
								end else if (count_q >= CAP) begin
									status_q <= ST_FULL;
								end else begin
									count_q <= count_q + 1'b1;
									sum_q   <= sum_q + val_ext;
								end
							end
							MODE_REMOVE: begin
								if (match_q) begin
									sum_q   <= sum_q - val_ext;
									idx_q   <= slot_q + 1'b1;
									state_q <= S_SHIFT;
								end else begin
									status_q <= ST_NOT_FOUND;
									state_q  <= S_DIVLD;
								end
							end
							default: begin
								occ_q   <= match_q;
								state_q <= S_DIVLD;
							end
						endcase
					end
				end
				S_SHIFT: begin
					// Each entry after the removed one moves down by one.
					if (idx_q < count_q) begin
						idx_q      <= idx_q + 1'b1;
						pend_q     <= 1'b1;
						pend_idx_q <= idx_q;
					end else begin
						pend_q <= 1'b0;
					end
					if (shift_done) begin
						count_q <= count_q - 1'b1;
						state_q <= S_DIVLD;
					end
				end
				S_DIVLD: begin
					if (count_q == '0) begin
						state_q <= S_DONE;
					end else begin
						dvd_q     <= prod_mag;
						quo_q     <= '0;
						rem_q     <= '0;
						neg_q     <= sum_q[SUM_W-1];
						div_cnt_q <= '0;
						state_q   <= S_DIV;
					end
				end
				S_DIV: begin
					// Restoring division, one quotient bit per cycle.
					dvd_q     <= {dvd_q[DIV_W-2:0], 1'b0};
					quo_q     <= {quo_q[DIV_W-2:0], trial_ge};
					rem_q     <= trial_ge ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == DCNT_W'(DIV_W - 1)) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= status_q;
						out_occ_q     <= occ_q;
						out_entries_q <= count_q;
						if (count_q == '0) begin
							out_lo_q   <= '0;
							out_hi_q   <= '0;
							out_mean_q <= '0;
						end else begin
							out_lo_q   <= lo_q;
							out_hi_q   <= hi_q;
							out_mean_q <= mean_full[MEAN_W-1:0];
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign occurrences = out_occ_q;
	assign entries     = out_entries_q;
	assign smallest    = out_lo_q;
	assign largest     = out_hi_q;
	assign mean_fixed  = out_mean_q;

endmodule
